// ----- rtl/dcf_pkg.sv -----
// dcf_pkg: shared types and constants of the dds channel command framer
// used by every rtl file of the block; depends on nothing else
package dcf_pkg;

  // field widths
  localparam int unsigned FREQ_IN_W  = 32;
  localparam int unsigned FREQ_W     = 29;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned PHASE_W    = 14;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned MAX_BYTES  = 7;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN = 4'd1;

  localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 29'd200000000;
  localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 29'd1;

  // tuning word = floor(f * 2^32 / 500e6) = floor(f * 2^24 / 1953125)
  localparam logic [20:0] TW_DIV = 21'd1953125;
  // reciprocal floor(2^53 / 1953125), 33 bits
  localparam logic [63:0] TW_RECIP_FULL = (64'd1 << 53) / 64'd1953125;
  localparam logic [32:0] TW_RECIP = TW_RECIP_FULL[32:0];

  // register addresses and fixed data of the serial port
  localparam logic [7:0] ADDR_CSR  = 8'h00;
  localparam logic [7:0] ADDR_FR1  = 8'h01;
  localparam logic [7:0] ADDR_CFTW = 8'h04;
  localparam logic [7:0] ADDR_CPOW = 8'h05;
  localparam logic [7:0] ADDR_ACR  = 8'h06;
  localparam logic [7:0] FR1_D0    = 8'hD0;
  localparam logic [7:0] CSR_CH0   = 8'h10;
  localparam logic [7:0] AMP_EN_HI = 8'h10;
  localparam logic [AMP_W-1:0] AMP_LIMIT = 16'd1023;

  typedef enum logic [1:0] {
    MODE_FREQ  = 2'd0,
    MODE_AMP   = 2'd1,
    MODE_PHASE = 2'd2,
    MODE_INIT  = 2'd3
  } dcf_mode_t;

  typedef struct packed {
    dcf_mode_t            mode;
    logic [CHAN_W-1:0]    channel;
    logic [AMP_W-1:0]     amp;
    logic [PHASE_W-1:0]   phase;
  } dcf_cmd_t;

  typedef struct packed {
    dcf_cmd_t             cmd;
    logic [WORD_W-1:0]    word;
  } dcf_job_t;

endpackage

// ----- rtl/dcf_tuning_pipe.sv -----
// dcf_tuning_pipe: input register and tuning word pipeline (clamp, reciprocal
// multiply in two partial products, remainder correction); uses dcf_pkg
module dcf_tuning_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dcf_pkg::dcf_cmd_t            in_cmd,
  input  logic [dcf_pkg::FREQ_IN_W-1:0] in_freq,
  input  logic [dcf_pkg::FREQ_W-1:0]   freq_max,
  input  logic [dcf_pkg::FREQ_W-1:0]   freq_min,
  output logic                         job_valid,
  output dcf_pkg::dcf_job_t            job,
  input  logic                         job_take
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] vld_r;
  dcf_pkg::dcf_cmd_t cmd_r [NSTG];
  logic adv;

  logic [dcf_pkg::FREQ_IN_W-1:0] s0_freq_r;
  logic [dcf_pkg::FREQ_W-1:0]    s1_fc_r, s1_fc_nxt;
  logic [dcf_pkg::FREQ_W-1:0]    s2_fc_r;
  logic [45:0]                   s2_plo_r, s2_plo_nxt;
  logic [45:0]                   s3_plo_r;
  logic [44:0]                   s3_phi_r, s3_phi_nxt;
  logic [61:0]                   s4_sum;
  logic [32:0]                   s4_q0_r;
  logic [32:0]                   s5_q0_r;
  logic [21:0]                   s5_m_r, s5_m_nxt;
  logic [21:0]                   s6_rem;
  logic [32:0]                   s6_q;
  logic [dcf_pkg::WORD_W-1:0]    s6_word_r, s6_word_nxt;

  // whole pipe moves together when the last stage is free or drained
  assign adv      = !vld_r[NSTG-1] || job_take;
  assign in_ready = adv;

  // clamp: upper bound first, the lower bound wins
  always_comb begin
    if (s0_freq_r > {3'b000, freq_max}) begin
      s1_fc_nxt = freq_max;
    end else begin
      s1_fc_nxt = s0_freq_r[dcf_pkg::FREQ_W-1:0];
    end
    if (s1_fc_nxt < freq_min) begin
      s1_fc_nxt = freq_min;
    end
  end

  assign s2_plo_nxt = 46'(s1_fc_r) * 46'(dcf_pkg::TW_RECIP[16:0]);
  assign s3_phi_nxt = 45'(s2_fc_r) * 45'(dcf_pkg::TW_RECIP[32:17]);
  assign s4_sum     = {16'b0, s3_plo_r} + {s3_phi_r, 17'b0};
  // only the low bits of q0 * d matter: remainder stays below 2 * d
  assign s5_m_nxt   = s4_q0_r[21:0] * {1'b0, dcf_pkg::TW_DIV};
  assign s6_rem     = 22'd0 - s5_m_r;
  assign s6_q       = s5_q0_r + {32'b0, (s6_rem >= {1'b0, dcf_pkg::TW_DIV})};
  assign s6_word_nxt = s6_q[32] ? {dcf_pkg::WORD_W{1'b1}} : s6_q[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r[0]  <= in_cmd;
      for (int i = 1; i < NSTG; i++) begin
        cmd_r[i] <= cmd_r[i-1];
      end
      s0_freq_r <= in_freq;
      s1_fc_r   <= s1_fc_nxt;
      s2_fc_r   <= s1_fc_r;
      s2_plo_r  <= s2_plo_nxt;
      s3_plo_r  <= s2_plo_r;
      s3_phi_r  <= s3_phi_nxt;
      s4_q0_r   <= s4_sum[61:29];
      s5_q0_r   <= s4_q0_r;
      s5_m_r    <= s5_m_nxt;
      s6_word_r <= s6_word_nxt;
    end
  end

  assign job_valid = vld_r[NSTG-1];
  assign job.cmd   = cmd_r[NSTG-1];
  assign job.word  = s6_word_r;

endmodule

// ----- rtl/dcf_frame_emitter.sv -----
// dcf_frame_emitter: turns one finished command into its frame bytes and
// drives the result register; uses dcf_pkg
module dcf_frame_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  dcf_pkg::dcf_job_t job,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_end,
  output logic              out_upd,
  output logic              out_last
);

  localparam int unsigned NB = dcf_pkg::MAX_BYTES;

  logic [7:0]    bytes_r [NB];
  logic [7:0]    bytes_nxt [NB];
  logic [NB-1:0] end_r, end_nxt;
  logic [NB-1:0] upd_r, upd_nxt;
  logic [2:0]    last_idx_r, last_idx_nxt;
  logic [2:0]    idx_r;
  logic          act_r;
  logic          produces;
  logic          load_out, send, fin;
  logic [7:0]    sel_byte;
  logic [dcf_pkg::AMP_W-1:0] amp_sat;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_end_r, out_upd_r, out_last_r;

  assign load_out = !out_valid_r || out_ready;
  assign send     = act_r && load_out;
  assign fin      = send && (idx_r == last_idx_r);
  assign job_take = !act_r || fin;

  assign produces = (job.cmd.mode == dcf_pkg::MODE_INIT) || !job.cmd.channel[2];
  assign sel_byte = dcf_pkg::CSR_CH0 << job.cmd.channel[1:0];
  assign amp_sat  = (job.cmd.amp > dcf_pkg::AMP_LIMIT) ? dcf_pkg::AMP_LIMIT : job.cmd.amp;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      bytes_nxt[i] = 8'h00;
    end
    end_nxt      = '0;
    upd_nxt      = '0;
    last_idx_nxt = 3'd0;
    // channel select frame leads modes 0 to 2
    bytes_nxt[0] = dcf_pkg::ADDR_CSR;
    bytes_nxt[1] = sel_byte;
    end_nxt[1]   = 1'b1;
    unique case (job.cmd.mode)
      dcf_pkg::MODE_FREQ: begin
        upd_nxt[1]   = 1'b1;
        bytes_nxt[2] = dcf_pkg::ADDR_CFTW;
        bytes_nxt[3] = job.word[31:24];
        bytes_nxt[4] = job.word[23:16];
        bytes_nxt[5] = job.word[15:8];
        bytes_nxt[6] = job.word[7:0];
        end_nxt[6]   = 1'b1;
        upd_nxt[6]   = 1'b1;
        last_idx_nxt = 3'd6;
      end
      dcf_pkg::MODE_AMP: begin
        upd_nxt[1]   = 1'b1;
        bytes_nxt[2] = dcf_pkg::ADDR_ACR;
        bytes_nxt[3] = 8'h00;
        bytes_nxt[4] = dcf_pkg::AMP_EN_HI | {6'b0, amp_sat[9:8]};
        bytes_nxt[5] = amp_sat[7:0];
        end_nxt[5]   = 1'b1;
        upd_nxt[5]   = 1'b1;
        last_idx_nxt = 3'd5;
      end
      dcf_pkg::MODE_PHASE: begin
        bytes_nxt[2] = dcf_pkg::ADDR_CPOW;
        bytes_nxt[3] = {2'b00, job.cmd.phase[13:8]};
        bytes_nxt[4] = job.cmd.phase[7:0];
        end_nxt[4]   = 1'b1;
        last_idx_nxt = 3'd4;
      end
      dcf_pkg::MODE_INIT: begin
        bytes_nxt[0] = dcf_pkg::ADDR_FR1;
        bytes_nxt[1] = dcf_pkg::FR1_D0;
        bytes_nxt[2] = 8'h00;
        bytes_nxt[3] = 8'h00;
        end_nxt      = '0;
        end_nxt[3]   = 1'b1;
        upd_nxt[3]   = 1'b1;
        last_idx_nxt = 3'd3;
      end
      default: begin
        last_idx_nxt = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_take && job_valid && produces) begin
        act_r <= 1'b1;
        idx_r <= 3'd0;
      end else if (fin) begin
        act_r <= 1'b0;
      end else if (send) begin
        idx_r <= idx_r + 3'd1;
      end
      if (send) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job_valid) begin
      bytes_r    <= bytes_nxt;
      end_r      <= end_nxt;
      upd_r      <= upd_nxt;
      last_idx_r <= last_idx_nxt;
    end
    if (send) begin
      out_byte_r <= bytes_r[idx_r];
      out_end_r  <= end_r[idx_r];
      out_upd_r  <= end_r[idx_r] && upd_r[idx_r];
      out_last_r <= (idx_r == last_idx_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_end   = out_end_r;
  assign out_upd   = out_upd_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/dds_channel_command_framer.sv -----
// dds_channel_command_framer: top level with configuration registers and
// stream ports; uses dcf_pkg, dcf_tuning_pipe and dcf_frame_emitter
// path: tuning pipe, frame register, result register; throughput: one frame
// byte per cycle while out_tready is high, set by the single byte output; a
// command is 4 to 7 bytes (init 4, phase 5, amplitude 6, frequency 7)
// reset: synchronous active-low rst_n empties the pipe and restores clamps
module dds_channel_command_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  // input request stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] channel, [34:3] frequency_hz, [50:35] amplitude_code,
  // [64:51] phase_word, [71:65] zero
  input  logic [71:0]                   in_tdata,
  // [1:0] mode
  input  logic [1:0]                    in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] serial_byte
  output logic [7:0]                    out_tdata,
  // [0] frame_end, [1] pulse_update
  output logic [1:0]                    out_tuser,
  // run_last
  output logic                          out_tlast,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcf_pkg::FREQ_W-1:0]    cfg_data
);

  logic [dcf_pkg::FREQ_W-1:0] freq_max_r;
  logic [dcf_pkg::FREQ_W-1:0] freq_min_r;

  dcf_pkg::dcf_cmd_t in_cmd;
  dcf_pkg::dcf_job_t job;
  logic              job_valid;
  logic              job_take;

  // configuration is always accepted; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_max_r <= dcf_pkg::FREQ_MAX_RST;
      freq_min_r <= dcf_pkg::FREQ_MIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcf_pkg::CFG_FREQ_MAX: freq_max_r <= cfg_data;
        dcf_pkg::CFG_FREQ_MIN: freq_min_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // unpack the request payload
  assign in_cmd.mode    = dcf_pkg::dcf_mode_t'(in_tuser);
  assign in_cmd.channel = in_tdata[2:0];
  assign in_cmd.amp     = in_tdata[50:35];
  assign in_cmd.phase   = in_tdata[64:51];

  // register stage, clamp and tuning word arithmetic
  dcf_tuning_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .in_freq   (in_tdata[34:3]),
    .freq_max  (freq_max_r),
    .freq_min  (freq_min_r),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // frame sequencing and the result register
  dcf_frame_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_end   (out_tuser[0]),
    .out_upd   (out_tuser[1]),
    .out_last  (out_tlast)
  );

endmodule
